@@ rtl/core/unordered_set_table_defines.svh @@
// Assertion macros used by the top level of the unordered set table RTL.
// Needs a clock named clk and a reset named rst in the using module.
`ifndef UNORDERED_SET_TABLE_DEFINES_SVH
`define UNORDERED_SET_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define UST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/core/ust_pkg.sv @@
// Package for the unordered set table: codes, microcode word and program.
// Used by the sequencer, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ust_pkg;

  localparam int DefaultStoreDepth = 16;
  localparam int DefaultValueWidth = 32;
  localparam int CapLimitReset = 16;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_ERASE  = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_SCAN,
    OP_DECIDE,
    OP_MOVE,
    OP_REPORT
  } uop_e;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_WAIT_START,
    COND_SCAN_MORE,
    COND_SKIP_MOVE,
    COND_ALWAYS
  } cond_e;

  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_SCAN   = 3'd1;
  localparam step_t STEP_DECIDE = 3'd2;
  localparam step_t STEP_MOVE   = 3'd3;
  localparam step_t STEP_REPORT = 3'd4;

  typedef struct packed {
    uop_e  uop;
    cond_e cond;
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic scan_more;
    logic need_move;
  } seq_status_t;

  // The control store: one word per step of the program.
  function automatic ctrl_word_t ucode_word(input step_t step);
    ctrl_word_t w;
    unique case (step)
      STEP_IDLE:   w = '{uop: OP_LOAD,   cond: COND_WAIT_START, target: STEP_IDLE};
      STEP_SCAN:   w = '{uop: OP_SCAN,   cond: COND_SCAN_MORE,  target: STEP_SCAN};
      STEP_DECIDE: w = '{uop: OP_DECIDE, cond: COND_SKIP_MOVE,  target: STEP_REPORT};
      STEP_MOVE:   w = '{uop: OP_MOVE,   cond: COND_NEXT,       target: STEP_REPORT};
      STEP_REPORT: w = '{uop: OP_REPORT, cond: COND_ALWAYS,     target: STEP_IDLE};
      default:     w = '{uop: OP_REPORT, cond: COND_ALWAYS,     target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/unordered_set_table.sv @@
// Top level of the unordered set table: configuration register, sequencer, datapath.
// Depends on ust_pkg, ust_sequencer, ust_datapath and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "unordered_set_table_defines.svh"

// A command is taken when start is high while busy is low, and its single result
// appears for exactly one cycle with done high; the result cannot be held off, so
// it must be captured in that cycle. A command holds busy high from the cycle after
// it is taken until the cycle after done, and the next command is taken once busy is
// low again. The length of a command is set by the entry scan, which reads one
// stored entry per cycle through the single read port of the entry store; an erase
// that hits adds a move step that copies the last entry into the freed slot. The
// limit register may be written at any time the block is idle.

module unordered_set_table
  import ust_pkg::*;
#(
  parameter int STORE_DEPTH = DefaultStoreDepth,
  parameter int VALUE_WIDTH = DefaultValueWidth,
  localparam int PosW = $clog2(STORE_DEPTH),
  localparam int CountW = $clog2(STORE_DEPTH + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [1:0]             action,
  input  wire logic [VALUE_WIDTH-1:0] item_value,
  output logic                        done,
  output logic [1:0]                  status,
  output logic                        found,
  output logic [PosW-1:0]             found_position,
  output logic [CountW-1:0]           entry_count,
  output logic                        is_empty,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CountW-1:0]      cfg_data
);

  localparam int LimitReset = (STORE_DEPTH < CapLimitReset) ? STORE_DEPTH : CapLimitReset;

  logic [CountW-1:0] capacity_limit;
  uop_e              uop;
  seq_status_t       dp_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CountW'(LimitReset);
    end else if (cfg_valid && cfg_ready) begin
      capacity_limit <= cfg_data;
    end
  end

  ust_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dp_status(dp_status),
    .uop      (uop),
    .busy     (busy)
  );

  ust_datapath #(
    .StoreDepth(STORE_DEPTH),
    .ValueWidth(VALUE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .uop         (uop),
    .action      (action),
    .item_value  (item_value),
    .cap_limit   (capacity_limit),
    .dp_status   (dp_status),
    .res_status  (status),
    .res_found   (found),
    .res_position(found_position),
    .res_count   (entry_count)
  );

  assign done     = (uop == OP_REPORT);
  assign is_empty = (entry_count == '0);

  `UST_ASSERT_NEXT(a_start_goes_busy, start && !busy, busy)
  `UST_ASSERT_NEXT(a_done_then_idle, done, !busy && !done)
  `UST_ASSERT_NOW(a_count_in_range, 1'b1, entry_count <= CountW'(STORE_DEPTH))
  `UST_ASSERT_NOW(a_miss_position_zero, done && !found, found_position == '0)

endmodule

`default_nettype wire

@@ rtl/core/ust_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; used by the unordered set table datapath.
`timescale 1ns / 1ps
`default_nettype none

module ust_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic      [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ rtl/core/ust_sequencer.sv @@
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on ust_pkg for the control word and the program.
`timescale 1ns / 1ps
`default_nettype none

module ust_sequencer
  import ust_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire seq_status_t dp_status,
  output uop_e             uop,
  output logic             busy
);

  step_t      step;
  step_t      step_next;
  ctrl_word_t ctrl;

  assign ctrl = ucode_word(step);
  assign uop  = ctrl.uop;
  assign busy = (step != STEP_IDLE);

  always_comb begin
    unique case (ctrl.cond)
      COND_NEXT:       step_next = step + 3'd1;
      COND_WAIT_START: step_next = start ? step + 3'd1 : ctrl.target;
      COND_SCAN_MORE:  step_next = dp_status.scan_more ? ctrl.target : step + 3'd1;
      COND_SKIP_MOVE:  step_next = dp_status.need_move ? step + 3'd1 : ctrl.target;
      COND_ALWAYS:     step_next = ctrl.target;
      default:         step_next = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ust_datapath.sv @@
// Datapath of the unordered set table: item registers, scan compare, fill count.
// Depends on ust_pkg and on the generic RAM ust_ram for the entry store.
`timescale 1ns / 1ps
`default_nettype none

module ust_datapath
  import ust_pkg::*;
#(
  parameter int StoreDepth = DefaultStoreDepth,
  parameter int ValueWidth = DefaultValueWidth,
  localparam int PosW = $clog2(StoreDepth),
  localparam int CountW = $clog2(StoreDepth + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire uop_e                  uop,
  input  wire logic [1:0]            action,
  input  wire logic [ValueWidth-1:0] item_value,
  input  wire logic [CountW-1:0]     cap_limit,
  output seq_status_t                dp_status,
  output logic [1:0]                 res_status,
  output logic                       res_found,
  output logic [PosW-1:0]            res_position,
  output logic [CountW-1:0]          res_count
);

  action_e               act;
  logic [ValueWidth-1:0] val;
  logic [CountW-1:0]     idx;
  logic                  cmp_valid;
  logic [PosW-1:0]       cmp_pos;
  logic                  hit;
  logic [PosW-1:0]       pos;
  logic [CountW-1:0]     count;
  status_e               stat;

  logic                  wr_en;
  logic [PosW-1:0]       wr_addr;
  logic [ValueWidth-1:0] wr_data;
  logic [PosW-1:0]       rd_addr;
  logic [ValueWidth-1:0] rd_data;
  logic [CountW-1:0]     eff_limit;
  logic                  match;
  logic                  idx_live;
  logic [CountW-1:0]     count_dec;

  ust_ram #(
    .Width(ValueWidth),
    .Depth(StoreDepth)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign eff_limit = (cap_limit > CountW'(StoreDepth)) ? CountW'(StoreDepth) : cap_limit;
  assign match     = cmp_valid && (rd_data == val);
  assign idx_live  = (idx < count);
  assign count_dec = count - CountW'(1);

  assign dp_status.scan_more = !match && (idx_live || cmp_valid);
  assign dp_status.need_move = (act == ACT_ERASE) && hit;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[PosW-1:0];
    wr_data = val;
    rd_addr = idx[PosW-1:0];
    unique case (uop)
      OP_DECIDE: begin
        rd_addr = count_dec[PosW-1:0];
        wr_en   = (act == ACT_INSERT) && (count < eff_limit) && !hit;
      end
      OP_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = pos;
        wr_data = rd_data;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cmp_valid <= 1'b0;
    end else begin
      unique case (uop)
        OP_LOAD: begin
          act       <= action_e'(action);
          val       <= item_value;
          idx       <= '0;
          cmp_valid <= 1'b0;
          hit       <= 1'b0;
          pos       <= '0;
          stat      <= ST_OK;
        end
        OP_SCAN: begin
          if (match) begin
            hit       <= 1'b1;
            pos       <= cmp_pos;
            cmp_valid <= 1'b0;
          end else begin
            cmp_valid <= idx_live;
            cmp_pos   <= idx[PosW-1:0];
            if (idx_live) begin
              idx <= idx + CountW'(1);
            end
          end
        end
        OP_DECIDE: begin
          unique case (act)
            ACT_INSERT: begin
              if (count >= eff_limit) begin
                stat <= ST_FULL;
              end else if (hit) begin
                stat <= ST_DUP;
              end else begin
                count <= count + CountW'(1);
              end
            end
            ACT_ERASE: begin
              if (hit) begin
                count <= count_dec;
              end else begin
                stat <= ST_MISSING;
              end
            end
            ACT_CLEAR: begin
              count <= '0;
              hit   <= 1'b0;
              pos   <= '0;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  assign res_status   = stat;
  assign res_found    = hit;
  assign res_position = pos;
  assign res_count    = count;

endmodule

`default_nettype wire
